### rtl/iplpm_pkg.sv
package iplpm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int NUM_W = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = 32;
   localparam int LEN_W = 6;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  prefix_len;
      logic [NUM_W-1:0]  count;
      logic              found;
      logic [NUM_W-1:0]  entry_number;
      logic [LEN_W-1:0]  matched_len;
   } query_type;

   typedef struct packed {
      logic              enable;
      logic [NUM_W-1:0]  slot;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  prefix_len;
   } write_type;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] shift;
      shift = MAX_LEN - len;
      if (len == '0) begin
         return '0;
      end
      return {ADDR_W{1'b1}} << shift;
   endfunction

endpackage

### rtl/iplpm_cell.sv
module iplpm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [iplpm_pkg::NUM_W-1:0]   cell_index,
   input  iplpm_pkg::write_type          wr,
   input  iplpm_pkg::query_type          q_prev,
   output iplpm_pkg::query_type          q_out
);

   logic [iplpm_pkg::ADDR_W-1:0] route_address_ff;
   logic [iplpm_pkg::LEN_W-1:0]  route_length_ff;
   iplpm_pkg::query_type         stage_ff;
   iplpm_pkg::query_type         stage_in;
   logic                         match;

   always_comb begin
      match = (cell_index < q_prev.count)
            && (route_length_ff <= q_prev.prefix_len)
            && (((route_address_ff ^ q_prev.address)
                 & iplpm_pkg::prefix_mask(route_length_ff)) == '0);
      stage_in = q_prev;
      if (match && (!q_prev.found || route_length_ff > q_prev.matched_len)) begin
         stage_in.found = 1'b1;
         stage_in.entry_number = cell_index + iplpm_pkg::NUM_W'(1);
         stage_in.matched_len = route_length_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.enable && wr.slot == cell_index) begin
         route_address_ff <= wr.address;
         route_length_ff <= wr.prefix_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign q_out = stage_ff;

endmodule

### rtl/ipv4_longest_prefix_match_unit.sv
// Each beat on the request side either appends a route (mode 0) or looks one up
// (mode 1). A lookup travels down a chain of one compare cell per table entry,
// one cell per clock cycle, each cell registering it, so its result strobes out
// of the register in the last cell. The chain is fully pipelined: busy stays low
// and a new beat may be given in every cycle, loads and lookups mixed freely.
// A lookup only sees routes loaded before it. Results leave in request order,
// one cycle each on rsp_strobe; the receiver cannot stall them and must take
// every result in the cycle it appears. Loads beyond the table depth are dropped.
module ipv4_longest_prefix_match_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic [iplpm_pkg::ADDR_W-1:0]        req_address,
   input  logic [iplpm_pkg::LEN_W-1:0]         req_prefix_len,
   output logic                                rsp_strobe,
   output logic                                rsp_found,
   output logic [iplpm_pkg::NUM_W-1:0]         rsp_entry_number,
   output logic [iplpm_pkg::LEN_W-1:0]         rsp_matched_len
);

   logic [iplpm_pkg::NUM_W-1:0] entry_count_ff;
   logic [iplpm_pkg::NUM_W-1:0] entry_count_in;
   logic [iplpm_pkg::LEN_W-1:0] len_clamped;
   logic                        accept;
   iplpm_pkg::write_type        wr;
   iplpm_pkg::query_type        link [iplpm_pkg::TABLE_DEPTH+1];

   assign busy = 1'b0;
   assign accept = start && !busy;
   assign len_clamped = (req_prefix_len > iplpm_pkg::MAX_LEN) ? iplpm_pkg::MAX_LEN
                                                              : req_prefix_len;

   always_comb begin
      wr.enable = accept && req_mode == iplpm_pkg::MODE_LOAD
                  && entry_count_ff < iplpm_pkg::NUM_W'(iplpm_pkg::TABLE_DEPTH);
      wr.slot = entry_count_ff;
      wr.address = req_address;
      wr.prefix_len = len_clamped;
      entry_count_in = entry_count_ff;
      if (wr.enable) begin
         entry_count_in = entry_count_ff + iplpm_pkg::NUM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   always_comb begin
      link[0].valid = accept && req_mode == iplpm_pkg::MODE_LOOKUP;
      link[0].address = req_address;
      link[0].prefix_len = len_clamped;
      link[0].count = entry_count_ff;
      link[0].found = 1'b0;
      link[0].entry_number = '0;
      link[0].matched_len = '0;
   end

   for (genvar i = 0; i < iplpm_pkg::TABLE_DEPTH; i++) begin : g_cell
      iplpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (iplpm_pkg::NUM_W'(i)),
         .wr         (wr),
         .q_prev     (link[i]),
         .q_out      (link[i+1])
      );
   end

   assign rsp_strobe = link[iplpm_pkg::TABLE_DEPTH].valid;
   assign rsp_found = link[iplpm_pkg::TABLE_DEPTH].found;
   assign rsp_entry_number = link[iplpm_pkg::TABLE_DEPTH].entry_number;
   assign rsp_matched_len = link[iplpm_pkg::TABLE_DEPTH].matched_len;

endmodule
